// ----- src/tph_pkg.sv -----
// ----------------------------------------------------------------------------
// tph_pkg: shared types and constants for the two-point heading pose block
// Fixed datapath widths, CORDIC arctangent table, threshold and register codes.
// ----------------------------------------------------------------------------
package tph_pkg;

  // default values of the top-level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 32;

  // CORDIC datapath: vector lanes and binary angle (full turn = 2^32)
  localparam int VEC_W        = 56;
  localparam int MAG_W        = 53;
  localparam int ANG_W        = 34;
  localparam int STEP_W       = 5;
  localparam int ATAN_ENTRIES = 24;

  // normalization: larger component ends up in [2^52, 2^53)
  localparam int NORM_TOP_BIT      = 52;
  localparam int NORM_COARSE_BIT   = 44;
  localparam int NORM_COARSE_SHIFT = 8;

  // rotation start value 1/K in Q2.30
  localparam int KINV_Q30 = 652032874;

  // Q2.30 to Q1.15 rounding
  localparam int Q15_W       = 16;
  localparam int Q_ROUND_BIT = 14;
  localparam int Q_SHIFT     = 15;
  localparam int Q15_MAX     = 32767;
  localparam int Q15_MIN     = -32768;

  // configuration registers
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;
  localparam int POS_THR_W   = 31;
  localparam int ORI_THR_W   = 15;
  localparam int POS_THR_RST = 655;
  localparam int ORI_THR_RST = 1638;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_THR = 1'b0,
    REG_ORI_THR = 1'b1
  } cfg_reg_e;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t QUARTER_TURN = ang_t'(1 << 30);

  // status from the deadband gate back to the sequencer
  typedef struct packed {
    logic done;
    logic emit;
  } gate_res_t;

  // atan(2^-i) as a binary angle
  function automatic ang_t atan_lut(logic [STEP_W-1:0] idx);
    ang_t a;
    case (idx)
      5'd0:    a = ang_t'(536870912);
      5'd1:    a = ang_t'(316933406);
      5'd2:    a = ang_t'(167458907);
      5'd3:    a = ang_t'(85004756);
      5'd4:    a = ang_t'(42667331);
      5'd5:    a = ang_t'(21354465);
      5'd6:    a = ang_t'(10679838);
      5'd7:    a = ang_t'(5340245);
      5'd8:    a = ang_t'(2670163);
      5'd9:    a = ang_t'(1335087);
      5'd10:   a = ang_t'(667544);
      5'd11:   a = ang_t'(333772);
      5'd12:   a = ang_t'(166886);
      5'd13:   a = ang_t'(83443);
      5'd14:   a = ang_t'(41722);
      5'd15:   a = ang_t'(20861);
      5'd16:   a = ang_t'(10430);
      5'd17:   a = ang_t'(5215);
      5'd18:   a = ang_t'(2608);
      5'd19:   a = ang_t'(1304);
      5'd20:   a = ang_t'(652);
      5'd21:   a = ang_t'(326);
      5'd22:   a = ang_t'(163);
      5'd23:   a = ang_t'(81);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/tph_cordic.sv -----
// ----------------------------------------------------------------------------
// tph_cordic: one CORDIC micro-rotation
// Shared by the vectoring pass (drive y to zero) and the rotation pass
// (drive z to zero). One step per use; the sequencer holds the registers.
// ----------------------------------------------------------------------------
module tph_cordic (
  input  tph_pkg::vec_t                    x_i,
  input  tph_pkg::vec_t                    y_i,
  input  tph_pkg::ang_t                    z_i,
  input  logic [tph_pkg::STEP_W-1:0]       idx_i,
  input  logic                             rot_i,
  output tph_pkg::vec_t                    x_o,
  output tph_pkg::vec_t                    y_o,
  output tph_pkg::ang_t                    z_o
);
  import tph_pkg::*;

  vec_t xs;
  vec_t ys;
  ang_t a;
  logic ccw;

  // shifted terms and table angle
  assign xs = x_i >>> idx_i;
  assign ys = y_i >>> idx_i;
  assign a  = atan_lut(idx_i);

  // rotation: turn toward z = 0; vectoring: turn toward y = 0
  assign ccw = rot_i ? !z_i[ANG_W-1] : y_i[VEC_W-1];

  always_comb begin
    if (ccw) begin
      x_o = x_i - ys;
      y_o = y_i + xs;
      z_o = z_i - a;
    end else begin
      x_o = x_i + ys;
      y_o = y_i - xs;
      z_o = z_i + a;
    end
  end

endmodule

// ----- src/tph_gate.sv -----
// ----------------------------------------------------------------------------
// tph_gate: deadband decision and stored pose
// Compares the new midpoint and quat z with the stored pose, squares the
// shift with one shared 31x31 multiplier, and updates the store on emit.
// ----------------------------------------------------------------------------
module tph_gate #(
  parameter int COORD_WIDTH = tph_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [COORD_WIDTH-1:0]         goal_x_i,
  input  logic signed [COORD_WIDTH-1:0]         goal_y_i,
  input  logic signed [tph_pkg::Q15_W-1:0]      quat_z_i,
  input  logic [tph_pkg::POS_THR_W-1:0]         pos_thr_i,
  input  logic [tph_pkg::ORI_THR_W-1:0]         ori_thr_i,
  output tph_pkg::gate_res_t                    res_o
);
  import tph_pkg::*;

  localparam int DW    = COORD_WIDTH + 1;
  localparam int CMP_W = (DW > POS_THR_W) ? DW : POS_THR_W;
  localparam int SQ_W  = 2 * POS_THR_W;
  localparam int ACC_W = SQ_W + 1;
  localparam int DQ_W  = Q15_W + 1;

  typedef enum logic [2:0] {
    G_IDLE,
    G_ABS,
    G_SQX,
    G_SQY,
    G_SQT,
    G_DEC
  } gate_state_e;

  gate_state_e                    state_q, state_d;
  logic                           have_q, have_d;
  logic signed [COORD_WIDTH-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic signed [Q15_W-1:0]        sqz_q, sqz_d;
  logic                           done_q, done_d, emit_q, emit_d;

  logic signed [DW-1:0]           ex_q, ex_d, ey_q, ey_d;
  logic signed [DQ_W-1:0]         dq_q, dq_d;
  logic [CMP_W-1:0]               ax_q, ax_d, ay_q, ay_d;
  logic                           far_q, far_d, turn_q, turn_d;
  logic [SQ_W-1:0]                prod_q, prod_d;
  logic [ACC_W-1:0]               acc_q, acc_d;

  logic [DW-1:0]                  axu, ayu;
  logic [DQ_W-1:0]                adq;
  logic [CMP_W-1:0]               thr_ext;
  logic [POS_THR_W-1:0]           mul_op;
  logic [SQ_W-1:0]                mul_res;
  logic                           emit;

  // magnitudes of the differences
  assign axu     = ex_q[DW-1] ? -ex_q : ex_q;
  assign ayu     = ey_q[DW-1] ? -ey_q : ey_q;
  assign adq     = dq_q[DQ_W-1] ? -dq_q : dq_q;
  assign thr_ext = CMP_W'(pos_thr_i);

  // shared squarer: x shift, y shift, then threshold
  always_comb begin
    case (state_q)
      G_SQX:   mul_op = ax_q[POS_THR_W-1:0];
      G_SQY:   mul_op = ay_q[POS_THR_W-1:0];
      default: mul_op = pos_thr_i;
    endcase
  end
  assign mul_res = SQ_W'(mul_op) * SQ_W'(mul_op);

  assign emit = !have_q || far_q || turn_q || (acc_q > ACC_W'(prod_q));

  always_comb begin
    state_d = state_q;
    have_d  = have_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    sqz_d   = sqz_q;
    done_d  = 1'b0;
    emit_d  = emit_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    dq_d    = dq_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    far_d   = far_q;
    turn_d  = turn_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          ex_d    = DW'(goal_x_i) - DW'(sx_q);
          ey_d    = DW'(goal_y_i) - DW'(sy_q);
          dq_d    = DQ_W'(quat_z_i) - DQ_W'(sqz_q);
          state_d = G_ABS;
        end
      end
      G_ABS: begin
        ax_d    = CMP_W'(axu);
        ay_d    = CMP_W'(ayu);
        far_d   = (CMP_W'(axu) > thr_ext) || (CMP_W'(ayu) > thr_ext);
        turn_d  = adq > DQ_W'(ori_thr_i);
        state_d = G_SQX;
      end
      G_SQX: begin
        prod_d  = mul_res;
        state_d = G_SQY;
      end
      G_SQY: begin
        acc_d   = ACC_W'(prod_q);
        prod_d  = mul_res;
        state_d = G_SQT;
      end
      G_SQT: begin
        acc_d   = acc_q + ACC_W'(prod_q);
        prod_d  = mul_res;
        state_d = G_DEC;
      end
      G_DEC: begin
        done_d = 1'b1;
        emit_d = emit;
        if (emit) begin
          have_d = 1'b1;
          sx_d   = goal_x_i;
          sy_d   = goal_y_i;
          sqz_d  = quat_z_i;
        end
        state_d = G_IDLE;
      end
      default: state_d = G_IDLE;
    endcase
  end

  // control and stored pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      have_q  <= 1'b0;
      sx_q    <= '0;
      sy_q    <= '0;
      sqz_q   <= '0;
      done_q  <= 1'b0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      have_q  <= have_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      sqz_q   <= sqz_d;
      done_q  <= done_d;
      emit_q  <= emit_d;
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    dq_q   <= dq_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    far_q  <= far_d;
    turn_q <= turn_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign res_o.done = done_q;
  assign res_o.emit = emit_q;

  // decision comes only out of the decide step
  a_done_from_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == G_DEC))
    else $error("gate done without decide step");

  // first pose after reset always goes out
  a_first_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !$past(have_q)) |-> emit_q)
    else $error("first pose suppressed");

  // once a pose is stored it stays stored
  a_have_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(have_q))
    else $error("stored pose lost");

endmodule

// ----- src/two_point_heading_pose_with_deadband.sv -----
// ----------------------------------------------------------------------------
// two_point_heading_pose_with_deadband: pose from two landmarks, deadbanded
// Midpoint and half-angle quaternion of the heading between two points,
// published only when position or orientation moved past the thresholds.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       first_x, first_y, second_x, second_y
//  m_axis    out        m_axis_tvalid/tready       goal_x, goal_y, quat_z, quat_w
//  cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
//  Each word goes through normalization by coarse and single-bit shifts,
//  then through the single shared CORDIC micro-rotation unit, which runs
//  the vectoring pass and then the rotation pass one step per cycle.
//  Coincident points skip vectoring.
//  s_axis_tready is high only while the sequencer is idle.
//  A finished result sits in the output register; the next word is taken
//  while it waits, and a new result waits only if that register is still full.
//  Reset clears the stored pose; thresholds return to 655 and 1638.
//
module two_point_heading_pose_with_deadband #(
  parameter int CORDIC_STEPS = tph_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_WIDTH  = tph_pkg::COORD_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration writes
  input  logic                                       cfg_we_i,
  input  logic [tph_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [tph_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  // input words
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // first_x, first_y, second_x, second_y (lowest first)
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  // result words
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // goal_x, goal_y, quat_z, quat_w (lowest first)
  output logic [((2*COORD_WIDTH+32+7)/8)*8-1:0]      m_axis_tdata
);
  import tph_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int OUT_W  = ((2*COORD_WIDTH+32+7)/8)*8;
  localparam int CNT_W  = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_NORM,
    ST_QUAD,
    ST_VEC,
    ST_HALF,
    ST_ROT,
    ST_ROUND,
    ST_GATE,
    ST_HOLD
  } seq_state_e;

  // rounding Q2.30 to saturated Q1.15
  function automatic logic signed [Q15_W-1:0] to_q15(vec_t v);
    vec_t r;
    logic signed [Q15_W-1:0] q;
    r = (v + vec_t'(1 << Q_ROUND_BIT)) >>> Q_SHIFT;
    if (r > vec_t'(Q15_MAX))      q = Q15_W'(Q15_MAX);
    else if (r < vec_t'(Q15_MIN)) q = Q15_W'(Q15_MIN);
    else                          q = r[Q15_W-1:0];
    return q;
  endfunction

  seq_state_e                 state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       m_valid_q, m_valid_d;
  logic                       gate_start_q, gate_start_d;
  logic [POS_THR_W-1:0]       pos_thr_q, pos_thr_d;
  logic [ORI_THR_W-1:0]       ori_thr_q, ori_thr_d;

  vec_t                       x_q, x_d, y_q, y_d;
  ang_t                       z_q, z_d;
  logic [MAG_W-1:0]           m_q, m_d;
  logic signed [CW-1:0]       gx_q, gx_d, gy_q, gy_d;
  logic signed [Q15_W-1:0]    qz_q, qz_d, qw_q, qw_d;
  logic [OUT_W-1:0]           out_q, out_d;

  logic signed [CW-1:0]       in_x1, in_y1, in_x2, in_y2;
  logic signed [CW:0]         sum_x, sum_y;
  vec_t                       abs_x, abs_y, abs_m;
  vec_t                       cx, cy;
  ang_t                       cz;
  logic                       in_acc, out_free, load_out;
  gate_res_t                  gate_res;

  // input word fields
  assign in_x1 = $signed(s_axis_tdata[CW-1:0]);
  assign in_y1 = $signed(s_axis_tdata[2*CW-1:CW]);
  assign in_x2 = $signed(s_axis_tdata[3*CW-1:2*CW]);
  assign in_y2 = $signed(s_axis_tdata[4*CW-1:3*CW]);
  assign sum_x = (CW+1)'(in_x1) + (CW+1)'(in_x2);
  assign sum_y = (CW+1)'(in_y1) + (CW+1)'(in_y2);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // larger magnitude of the heading vector
  assign abs_x = x_q[VEC_W-1] ? -x_q : x_q;
  assign abs_y = y_q[VEC_W-1] ? -y_q : y_q;
  assign abs_m = (abs_x > abs_y) ? abs_x : abs_y;

  // shared micro-rotation unit
  tph_cordic u_cordic (
    .x_i   (x_q),
    .y_i   (y_q),
    .z_i   (z_q),
    .idx_i (STEP_W'(cnt_q)),
    .rot_i (state_q == ST_ROT),
    .x_o   (cx),
    .y_o   (cy),
    .z_o   (cz)
  );

  // deadband decision and stored pose
  tph_gate #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_gate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (gate_start_q),
    .goal_x_i  (gx_q),
    .goal_y_i  (gy_q),
    .quat_z_i  (qz_q),
    .pos_thr_i (pos_thr_q),
    .ori_thr_i (ori_thr_q),
    .res_o     (gate_res)
  );

  // configuration writes
  always_comb begin
    pos_thr_d = pos_thr_q;
    ori_thr_d = ori_thr_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POS_THR: pos_thr_d = cfg_data_i[POS_THR_W-1:0];
        REG_ORI_THR: ori_thr_d = cfg_data_i[ORI_THR_W-1:0];
        default:     ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    gate_start_d = 1'b0;
    load_out     = 1'b0;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    m_d          = m_q;
    gx_d         = gx_q;
    gy_d         = gy_q;
    qz_d         = qz_q;
    qw_d         = qw_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_d     = vec_t'(in_x2) - vec_t'(in_x1);
          y_d     = vec_t'(in_y1) - vec_t'(in_y2);
          gx_d    = sum_x[CW:1];
          gy_d    = sum_y[CW:1];
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        m_d     = abs_m[MAG_W-1:0];
        state_d = ST_NORM;
      end
      ST_NORM: begin
        // coincident points give heading zero
        if (m_q == '0) begin
          z_d     = '0;
          state_d = ST_HALF;
        end else if (!(|m_q[MAG_W-1:NORM_COARSE_BIT])) begin
          x_d = x_q <<< NORM_COARSE_SHIFT;
          y_d = y_q <<< NORM_COARSE_SHIFT;
          m_d = m_q << NORM_COARSE_SHIFT;
        end else if (!m_q[NORM_TOP_BIT]) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
          m_d = m_q << 1;
        end else begin
          state_d = ST_QUAD;
        end
      end
      ST_QUAD: begin
        // fold the left half plane by a quarter turn
        z_d = '0;
        if (x_q[VEC_W-1]) begin
          if (!y_q[VEC_W-1]) begin
            x_d = y_q;
            y_d = -x_q;
            z_d = QUARTER_TURN;
          end else begin
            x_d = -y_q;
            y_d = x_q;
            z_d = -QUARTER_TURN;
          end
        end
        cnt_d   = '0;
        state_d = ST_VEC;
      end
      ST_VEC: begin
        x_d = cx;
        y_d = cy;
        z_d = cz;
        if (cnt_q == LAST_STEP) state_d = ST_HALF;
        else                    cnt_d   = cnt_q + 1'b1;
      end
      ST_HALF: begin
        z_d     = z_q >>> 1;
        x_d     = vec_t'(KINV_Q30);
        y_d     = '0;
        cnt_d   = '0;
        state_d = ST_ROT;
      end
      ST_ROT: begin
        x_d = cx;
        y_d = cy;
        z_d = cz;
        if (cnt_q == LAST_STEP) state_d = ST_ROUND;
        else                    cnt_d   = cnt_q + 1'b1;
      end
      ST_ROUND: begin
        qz_d         = to_q15(y_q);
        qw_d         = to_q15(x_q);
        gate_start_d = 1'b1;
        state_d      = ST_GATE;
      end
      ST_GATE: begin
        if (gate_res.done) begin
          if (!gate_res.emit) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_d     = out_q;
    m_valid_d = m_valid_q;
    if (load_out) begin
      out_d     = OUT_W'({qw_q, qz_q, gy_q, gx_q});
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      m_valid_q    <= 1'b0;
      gate_start_q <= 1'b0;
      pos_thr_q    <= POS_THR_W'(POS_THR_RST);
      ori_thr_q    <= ORI_THR_W'(ORI_THR_RST);
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      m_valid_q    <= m_valid_d;
      gate_start_q <= gate_start_d;
      pos_thr_q    <= pos_thr_d;
      ori_thr_q    <= ori_thr_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    m_q   <= m_d;
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    qz_q  <= qz_d;
    qw_q  <= qw_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  // a result appears only after the gate decided or from the hold state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_GATE || state_q == ST_HOLD))
    else $error("result word without a decision");

  // gate answers only while the sequencer waits for it
  a_gate_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gate_res.done |-> (state_q == ST_GATE))
    else $error("gate answer outside wait state");

  // vectoring starts from a normalized magnitude
  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QUAD) |-> m_q[NORM_TOP_BIT])
    else $error("vector not normalized");

  // step counter stays inside the table
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VEC || state_q == ST_ROT) |-> (cnt_q <= LAST_STEP))
    else $error("CORDIC step out of range");

endmodule
